@@ rtl/mlp_pkg.sv @@
// ----------------------------------------------------------------------------
// mlp_pkg
// Types, constants and arithmetic helpers for the Q8.8 perceptron unit.
// ----------------------------------------------------------------------------
package mlp_pkg;

    localparam int MAX_LAYERS  = 4;
    localparam int MAX_NEURONS = 16;
    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int SLOTS       = MAX_NEURONS + 1;
    localparam int BIAS_IX     = MAX_NEURONS;
    localparam int NMAT        = MAX_LAYERS - 1;
    localparam int W_DEPTH     = NMAT * SLOTS * SLOTS;
    localparam int N_DEPTH     = MAX_LAYERS * SLOTS;
    localparam int WA_W        = $clog2(W_DEPTH);
    localparam int NA_W        = $clog2(N_DEPTH);
    localparam int ACC_W       = 37;

    localparam logic signed [DATA_WIDTH-1:0] ONE_Q = 16'sd256;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_INPUT  = 2'd1,
        OP_TARGET = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_LAYER_COUNT = 3'd0,
        REG_WIDTH0      = 3'd1,
        REG_WIDTH1      = 3'd2,
        REG_WIDTH2      = 3'd3,
        REG_WIDTH3      = 3'd4,
        REG_LEARN_RATE  = 3'd5
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_RD_OUT,
        S_MAC,
        S_RND,
        S_SIG,
        S_SIGQ,
        S_F_WR,
        S_B_ORD,
        S_B_OWR,
        S_B_DWR,
        S_U_G0,
        S_U_G1,
        S_U_G2,
        S_U_G3,
        S_U_R0,
        S_U_R1,
        S_U_R2,
        S_U_R3
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767)
            r = 16'sh7FFF;
        else if (v < -40'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [4:0] clamp_width(input logic [4:0] w);
        logic [4:0] r;
        if (w == 5'd0)
            r = 5'd1;
        else if (w > 5'(MAX_NEURONS))
            r = 5'(MAX_NEURONS);
        else
            r = w;
        return r;
    endfunction

    function automatic logic [NA_W-1:0] n_addr(input logic [1:0] lay, input logic [4:0] ix);
        return NA_W'(lay) * NA_W'(SLOTS) + NA_W'(ix);
    endfunction

    function automatic logic [WA_W-1:0] w_addr(input logic [1:0] m, input logic [4:0] row,
                                               input logic [4:0] col);
        return WA_W'(m) * WA_W'(SLOTS * SLOTS) + WA_W'(row) * WA_W'(SLOTS) + WA_W'(col);
    endfunction

    // sigmoid samples at steps of 0.25, q0.16
    function automatic logic [15:0] sig_tab(input logic [5:0] ix);
        logic [15:0] r;
        case (ix)
            6'd0:  r = 16'd32768;
            6'd1:  r = 16'd36843;
            6'd2:  r = 16'd40793;
            6'd3:  r = 16'd44511;
            6'd4:  r = 16'd47911;
            6'd5:  r = 16'd50941;
            6'd6:  r = 16'd53581;
            6'd7:  r = 16'd55834;
            6'd8:  r = 16'd57724;
            6'd9:  r = 16'd59287;
            6'd10: r = 16'd60565;
            6'd11: r = 16'd61598;
            6'd12: r = 16'd62428;
            6'd13: r = 16'd63090;
            6'd14: r = 16'd63615;
            6'd15: r = 16'd64030;
            6'd16: r = 16'd64357;
            6'd17: r = 16'd64614;
            6'd18: r = 16'd64816;
            6'd19: r = 16'd64974;
            6'd20: r = 16'd65097;
            6'd21: r = 16'd65194;
            6'd22: r = 16'd65269;
            6'd23: r = 16'd65328;
            6'd24: r = 16'd65374;
            6'd25: r = 16'd65410;
            6'd26: r = 16'd65438;
            6'd27: r = 16'd65461;
            6'd28: r = 16'd65476;
            6'd29: r = 16'd65486;
            6'd30: r = 16'd65496;
            6'd31: r = 16'd65504;
            default: r = 16'd65510;
        endcase
        return r;
    endfunction

    // q0.16 sigmoid of a q8.8 value, interpolated with floor
    function automatic logic [15:0] sig16(input logic signed [15:0] x);
        logic [15:0] a;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [17:0] pr;
        logic [15:0] s;
        a = x[15] ? (~x + 16'd1) : x;
        lo = sig_tab({1'b0, a[10:6]});
        hi = sig_tab(6'({1'b0, a[10:6]} + 6'd1));
        pr = 18'(hi - lo) * 18'(a[5:0]);
        if (a >= 16'd2048)
            s = sig_tab(6'd32);
        else
            s = lo + 16'(pr >> 6);
        return x[15] ? 16'(17'h10000 - 17'(s)) : s;
    endfunction

endpackage

@@ rtl/mlp_sigmoid_infer_train_unit.sv @@
// ----------------------------------------------------------------------------
// mlp_sigmoid_infer_train_unit
// Q8.8 multilayer perceptron with sigmoid hidden layers, inference and
// online backpropagation, state held in synchronous memories.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready is high only while the unit is idle.
// A weight write or an element load is done in the idle state. A weight
// read passes through S_RD_WAIT and S_RD_OUT and waits for the output
// register to be free. The last input element runs the forward pass on one
// shared multiply-accumulate unit fed by the weight memory read port: each
// neuron of layer l reads, multiplies and accumulates every weight and the
// bias, drains the pipeline, rounds, applies the sigmoid in hidden layers
// and writes back, and output beats wait for out_ready. The last target
// element runs the backward pass: output deltas, then a multiply-accumulate
// per hidden delta, then per column a gradient step and a read-modify-write
// of each used weight, through the weight memory's one read and one write
// port. There is no clearing pass after reset.
module mlp_sigmoid_infer_train_unit
    import mlp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [1:0]          matrix_sel,
    input  logic [4:0]          row_idx,
    input  logic [4:0]          col_idx,
    input  logic signed [15:0]  data_value,
    input  logic                is_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  out_value,
    output logic [4:0]          out_index,
    output logic                out_last
);

    // configuration
    logic [2:0]  layer_count_reg;
    logic [4:0]  width_reg [0:3];
    logic [15:0] learn_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= 3'd3;
            width_reg[0]    <= 5'd16;
            width_reg[1]    <= 5'd16;
            width_reg[2]    <= 5'd16;
            width_reg[3]    <= 5'd16;
            learn_rate_reg  <= 16'd3277;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LAYER_COUNT: layer_count_reg <= cfg_data[2:0];
                REG_WIDTH0:      width_reg[0]    <= cfg_data[4:0];
                REG_WIDTH1:      width_reg[1]    <= cfg_data[4:0];
                REG_WIDTH2:      width_reg[2]    <= cfg_data[4:0];
                REG_WIDTH3:      width_reg[3]    <= cfg_data[4:0];
                REG_LEARN_RATE:  learn_rate_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic [4:0] wid [0:3];
    logic [2:0] nl;
    logic [1:0] o_lay;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            wid[i] = clamp_width(width_reg[i]);
        if (layer_count_reg < 3'd2)
            nl = 3'd2;
        else if (layer_count_reg > 3'(MAX_LAYERS))
            nl = 3'(MAX_LAYERS);
        else
            nl = layer_count_reg;
        o_lay = 2'(nl - 3'd1);
    end

    // memories
    logic [15:0]         wmem [0:W_DEPTH-1];
    logic [15:0]         nmem [0:N_DEPTH-1];
    logic [15:0]         dmem [0:N_DEPTH-1];
    logic                w_we, n_we, d_we;
    logic [WA_W-1:0]     w_waddr, w_raddr;
    logic [NA_W-1:0]     n_waddr, n_raddr, d_waddr, d_raddr;
    logic signed [15:0]  w_wdata, n_wdata, d_wdata;
    logic signed [15:0]  w_q, n_q, d_q;

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_waddr] <= w_wdata;
        w_q <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
            nmem[n_waddr] <= n_wdata;
        n_q <= nmem[n_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            dmem[d_waddr] <= d_wdata;
        d_q <= dmem[d_raddr];
    end

    // control and datapath registers
    state_t              state_reg, state_next;
    logic                fwd_reg, fwd_next;
    logic [1:0]          lay_reg, lay_next;
    logic [4:0]          idx_reg, idx_next;
    logic [4:0]          k_reg, k_next;
    logic [4:0]          rrow_reg, rrow_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                prod_vld_reg, prod_vld_next;
    logic signed [31:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [15:0]  val_reg, val_next;
    logic [15:0]         sig_reg, sig_next;
    logic signed [15:0]  dlt_reg, dlt_next;
    logic [6:0]          sd_reg, sd_next;
    logic signed [15:0]  g_reg, g_next;
    logic signed [15:0]  t_reg, t_next;
    logic signed [15:0]  wv_reg, wv_next;
    logic signed [17:0]  step_reg, step_next;
    logic [1:0]          lsel_reg, lsel_next;
    logic [4:0]          lrow_reg, lrow_next;
    logic [4:0]          lcol_reg, lcol_next;
    logic                lok_reg, lok_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [15:0]  out_value_reg, out_value_next;
    logic [4:0]          out_index_reg, out_index_next;
    logic                out_last_reg, out_last_next;
    logic [N_DEPTH-1:0]  nv_reg;
    logic                nv_q, n_one, n_one_q;
    logic signed [15:0]  tgt_reg [0:MAX_NEURONS-1];
    logic                tgt_we;

    // combinational helpers
    logic [4:0]          ncnt, nterms;
    logic                issuing, out_free;
    logic signed [15:0]  nval, opa;
    logic signed [ACC_W-1:0] acc_r;
    logic signed [31:0]  pa, pb;
    logic signed [23:0]  ga, gb, gp;
    logic signed [31:0]  tp;
    logic signed [32:0]  la, lb, lp;
    logic [15:0]         om;
    logic [31:0]         dp;
    logic signed [16:0]  tdiff;
    logic signed [18:0]  wsum;

    assign nval     = n_one_q ? ONE_Q : (nv_q ? n_q : 16'sd0);
    assign opa      = fwd_reg ? nval : d_q;
    assign ncnt     = fwd_reg ? wid[2'(lay_reg - 2'd1)] : wid[2'(lay_reg + 2'd1)];
    assign nterms   = fwd_reg ? 5'(ncnt + 5'd1) : ncnt;
    assign issuing  = (k_reg < nterms);
    assign out_free = !out_valid_reg || out_ready;
    assign acc_r    = (acc_reg + ACC_W'(128)) >>> FRAC_BITS;

    always_comb
    begin
        pa    = 32'(opa);
        pb    = 32'(w_q);
        ga    = 24'(dlt_reg);
        gb    = {17'd0, sd_reg};
        gp    = ga * gb;
        tp    = 32'(g_reg) * 32'(nval);
        la    = {17'd0, learn_rate_reg};
        lb    = 33'(t_reg);
        lp    = la * lb;
        om    = 16'(17'h10000 - {1'b0, sig_reg});
        dp    = 32'(sig_reg) * 32'(om);
        tdiff = 17'(tgt_reg[idx_reg[3:0]]) - 17'(nval);
        wsum  = 19'(wv_reg) + 19'(step_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        fwd_next       = fwd_reg;
        lay_next       = lay_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        rrow_next      = rrow_reg;
        rd_vld_next    = 1'b0;
        prod_vld_next  = 1'b0;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        val_next       = val_reg;
        sig_next       = sig_reg;
        dlt_next       = dlt_reg;
        sd_next        = sd_reg;
        g_next         = g_reg;
        t_next         = t_reg;
        wv_next        = wv_reg;
        step_next      = step_reg;
        lsel_next      = lsel_reg;
        lrow_next      = lrow_reg;
        lcol_next      = lcol_reg;
        lok_next       = lok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        w_we    = 1'b0;
        w_waddr = w_addr(lay_reg, rrow_reg, idx_reg);
        w_wdata = sat16(40'(wsum));
        w_raddr = w_addr(lsel_reg, lrow_reg, lcol_reg);
        n_we    = 1'b0;
        n_waddr = n_addr(lay_reg, idx_reg);
        n_wdata = val_reg;
        n_raddr = n_addr(lay_reg, idx_reg);
        d_we    = 1'b0;
        d_waddr = n_addr(lay_reg, idx_reg);
        d_wdata = val_reg;
        d_raddr = n_addr(2'(lay_reg + 2'd1), idx_reg);
        tgt_we  = 1'b0;
        n_one   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_WRITE:
                        begin
                            w_waddr = w_addr(matrix_sel, row_idx, col_idx);
                            w_wdata = data_value;
                            w_we    = (matrix_sel < 2'(NMAT)) && (row_idx <= 5'(BIAS_IX))
                                      && (col_idx <= 5'(BIAS_IX));
                        end
                        OP_READ:
                        begin
                            lsel_next  = matrix_sel;
                            lrow_next  = row_idx;
                            lcol_next  = col_idx;
                            lok_next   = (matrix_sel < 2'(NMAT)) && (row_idx <= 5'(BIAS_IX))
                                         && (col_idx <= 5'(BIAS_IX));
                            state_next = S_RD_WAIT;
                        end
                        OP_INPUT:
                        begin
                            n_waddr = n_addr(2'd0, col_idx);
                            n_wdata = data_value;
                            n_we    = (col_idx < 5'(MAX_NEURONS));
                            if (is_last)
                            begin
                                fwd_next   = 1'b1;
                                lay_next   = 2'd1;
                                idx_next   = 5'd0;
                                k_next     = 5'd0;
                                acc_next   = '0;
                                state_next = S_MAC;
                            end
                        end
                        default:
                        begin
                            tgt_we = (col_idx < 5'(MAX_NEURONS));
                            if (is_last)
                            begin
                                fwd_next   = 1'b0;
                                idx_next   = 5'd0;
                                state_next = S_B_ORD;
                            end
                        end
                    endcase
                end
            end

            S_RD_WAIT:
                state_next = S_RD_OUT;

            S_RD_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = lok_reg ? w_q : 16'sd0;
                    out_index_next = lcol_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // shared multiply-accumulate: read, multiply, add
            S_MAC:
            begin
                if (fwd_reg)
                begin
                    n_one   = issuing && (k_reg == ncnt);
                    n_raddr = n_addr(2'(lay_reg - 2'd1), (k_reg == ncnt) ? 5'(BIAS_IX) : k_reg);
                    w_raddr = w_addr(2'(lay_reg - 2'd1), (k_reg == ncnt) ? 5'(BIAS_IX) : k_reg,
                                     idx_reg);
                end
                else
                begin
                    d_raddr = n_addr(2'(lay_reg + 2'd1), k_reg);
                    w_raddr = w_addr(lay_reg, idx_reg, k_reg);
                end
                if (issuing)
                    k_next = 5'(k_reg + 5'd1);
                rd_vld_next   = issuing;
                prod_vld_next = rd_vld_reg;
                if (rd_vld_reg)
                    prod_next = pa * pb;
                if (prod_vld_reg)
                    acc_next = acc_reg + ACC_W'(prod_reg);
                if (!issuing && !rd_vld_reg && !prod_vld_reg)
                    state_next = S_RND;
            end

            S_RND:
            begin
                val_next = sat16(40'(acc_r));
                if (!fwd_reg)
                    state_next = S_B_DWR;
                else if (lay_reg < o_lay)
                    state_next = S_SIG;
                else
                    state_next = S_F_WR;
            end

            S_SIG:
            begin
                sig_next   = sig16(val_reg);
                state_next = S_SIGQ;
            end

            S_SIGQ:
            begin
                val_next   = 16'((17'(sig_reg) + 17'd128) >> 8);
                state_next = S_F_WR;
            end

            S_F_WR:
            begin
                if (lay_reg != o_lay || out_free)
                begin
                    n_we = 1'b1;
                    if (lay_reg == o_lay)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = val_reg;
                        out_index_next = idx_reg;
                        out_last_next  = (5'(idx_reg + 5'd1) == wid[lay_reg]);
                    end
                    k_next   = 5'd0;
                    acc_next = '0;
                    if (5'(idx_reg + 5'd1) < wid[lay_reg])
                    begin
                        idx_next   = 5'(idx_reg + 5'd1);
                        state_next = S_MAC;
                    end
                    else if (lay_reg < o_lay)
                    begin
                        lay_next   = 2'(lay_reg + 2'd1);
                        idx_next   = 5'd0;
                        state_next = S_MAC;
                    end
                    else
                        state_next = S_IDLE;
                end
            end

            S_B_ORD:
            begin
                n_raddr    = n_addr(o_lay, idx_reg);
                state_next = S_B_OWR;
            end

            S_B_OWR:
            begin
                d_waddr  = n_addr(o_lay, idx_reg);
                d_wdata  = sat16(40'(tdiff));
                d_we     = 1'b1;
                k_next   = 5'd0;
                acc_next = '0;
                if (5'(idx_reg + 5'd1) < wid[o_lay])
                begin
                    idx_next   = 5'(idx_reg + 5'd1);
                    state_next = S_B_ORD;
                end
                else if (o_lay >= 2'd2)
                begin
                    lay_next   = 2'(o_lay - 2'd1);
                    idx_next   = 5'd0;
                    state_next = S_MAC;
                end
                else
                begin
                    lay_next   = 2'd0;
                    idx_next   = 5'd0;
                    state_next = S_U_G0;
                end
            end

            S_B_DWR:
            begin
                d_we     = 1'b1;
                k_next   = 5'd0;
                acc_next = '0;
                if (5'(idx_reg + 5'd1) < wid[lay_reg])
                begin
                    idx_next   = 5'(idx_reg + 5'd1);
                    state_next = S_MAC;
                end
                else if (lay_reg > 2'd1)
                begin
                    lay_next   = 2'(lay_reg - 2'd1);
                    idx_next   = 5'd0;
                    state_next = S_MAC;
                end
                else
                begin
                    lay_next   = 2'd0;
                    idx_next   = 5'd0;
                    state_next = S_U_G0;
                end
            end

            // per column: gradient factor from delta and sigma prime
            S_U_G0:
            begin
                n_raddr    = n_addr(2'(lay_reg + 2'd1), idx_reg);
                d_raddr    = n_addr(2'(lay_reg + 2'd1), idx_reg);
                state_next = S_U_G1;
            end

            S_U_G1:
            begin
                sig_next   = sig16(nval);
                dlt_next   = d_q;
                state_next = S_U_G2;
            end

            S_U_G2:
            begin
                sd_next    = 7'((17'(dp[31:16]) + 17'd128) >> 8);
                state_next = S_U_G3;
            end

            S_U_G3:
            begin
                g_next     = sat16(40'((gp + 24'sd128) >>> FRAC_BITS));
                rrow_next  = 5'd0;
                state_next = S_U_R0;
            end

            // per weight: read, scale, step, write back
            S_U_R0:
            begin
                w_raddr    = w_addr(lay_reg, rrow_reg, idx_reg);
                n_raddr    = n_addr(lay_reg, rrow_reg);
                n_one      = (rrow_reg == 5'(BIAS_IX));
                state_next = S_U_R1;
            end

            S_U_R1:
            begin
                t_next     = sat16(40'((tp + 32'sd128) >>> FRAC_BITS));
                wv_next    = w_q;
                state_next = S_U_R2;
            end

            S_U_R2:
            begin
                step_next  = 18'((lp + 33'sd32768) >>> 16);
                state_next = S_U_R3;
            end

            S_U_R3:
            begin
                w_we = 1'b1;
                if (rrow_reg == 5'(BIAS_IX))
                begin
                    if (5'(idx_reg + 5'd1) < wid[2'(lay_reg + 2'd1)])
                    begin
                        idx_next   = 5'(idx_reg + 5'd1);
                        state_next = S_U_G0;
                    end
                    else if (2'(lay_reg + 2'd1) < o_lay)
                    begin
                        lay_next   = 2'(lay_reg + 2'd1);
                        idx_next   = 5'd0;
                        state_next = S_U_G0;
                    end
                    else
                        state_next = S_IDLE;
                end
                else
                begin
                    // bias row follows the last used row
                    if (5'(rrow_reg + 5'd1) < wid[lay_reg])
                        rrow_next = 5'(rrow_reg + 5'd1);
                    else
                        rrow_next = 5'(BIAS_IX);
                    state_next = S_U_R0;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fwd_reg       <= 1'b0;
            lay_reg       <= 2'd0;
            idx_reg       <= 5'd0;
            k_reg         <= 5'd0;
            rrow_reg      <= 5'd0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            nv_reg        <= '0;
            nv_q          <= 1'b0;
            n_one_q       <= 1'b0;
            for (int i = 0; i < MAX_NEURONS; i++)
                tgt_reg[i] <= 16'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            fwd_reg       <= fwd_next;
            lay_reg       <= lay_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            rrow_reg      <= rrow_next;
            rd_vld_reg    <= rd_vld_next;
            prod_vld_reg  <= prod_vld_next;
            out_valid_reg <= out_valid_next;
            nv_q          <= nv_reg[n_raddr];
            n_one_q       <= n_one;
            if (n_we)
                nv_reg[n_waddr] <= 1'b1;
            if (tgt_we)
                tgt_reg[col_idx[3:0]] <= data_value;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        val_reg       <= val_next;
        sig_reg       <= sig_next;
        dlt_reg       <= dlt_next;
        sd_reg        <= sd_next;
        g_reg         <= g_next;
        t_reg         <= t_next;
        wv_reg        <= wv_next;
        step_reg      <= step_next;
        lsel_reg      <= lsel_next;
        lrow_reg      <= lrow_next;
        lcol_reg      <= lcol_next;
        lok_reg       <= lok_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    // the accumulator is rounded only once the pipeline has drained
    a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RND |-> !rd_vld_reg && !prod_vld_reg)
        else $error("rounding with multiply-accumulate still in flight");

    // neuron writes never land on a bias slot
    a_no_bias_write: assert property (@(posedge clk) disable iff (!rst_n)
        n_we |-> n_waddr < NA_W'(N_DEPTH) && (state_reg == S_IDLE || idx_reg < 5'(BIAS_IX)))
        else $error("neuron write outside the used slots");

    // a weight written back was read in S_U_R0 at the same address
    a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_U_R3 |-> $past(state_reg, 3) == S_U_R0 && $past(w_raddr, 3) == w_waddr)
        else $error("weight update written to a different entry");
`endif

endmodule
